### rtl/hctf_pkg.sv
// shared types and constants for the hard clip tone filter
`default_nettype none

package hctf_pkg;

    // default widths of the sample and coefficient datapath
    localparam int SAMPLE_BITS_DEF = 24;
    localparam int COEFF_BITS_DEF  = 16;

    // register widths
    localparam int GAIN_W     = 16;
    localparam int CLIP_LVL_W = 24;
    localparam int TRIM_W     = 16;
    localparam int LIMIT_W    = 23;

    // fraction bits dropped after gain and trim products
    localparam int GAIN_FRAC = 8;
    localparam int TRIM_FRAC = 15;

    // clipped value and filter state stay below 2^24 in magnitude
    localparam int CLIP_W = 25;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // register reset values
    localparam logic [GAIN_W-1:0]     PRE_GAIN_RST     = 16'd6400;
    localparam logic [CLIP_LVL_W-1:0] CLIP_LEVEL_RST   = 24'd8388608;
    localparam int                    FILTER_COEFF_R16 = 37330;
    localparam logic [TRIM_W-1:0]     POST_SCALE_RST   = 16'd32768;
    localparam logic [LIMIT_W-1:0]    PEAK_LIMIT_RST   = 23'd8388607;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PRE_GAIN     = 3'd0,
        REG_CLIP_LEVEL   = 3'd1,
        REG_FILTER_COEFF = 3'd2,
        REG_POST_SCALE   = 3'd3,
        REG_PEAK_LIMIT   = 3'd4
    } t_reg_idx;

    // operand pair routed to the shared multiplier
    typedef enum logic [1:0] {
        MUL_GAIN = 2'd0,
        MUL_FB   = 2'd1,
        MUL_FF   = 2'd2,
        MUL_TRIM = 2'd3
    } t_mul_sel;

    typedef struct packed {
        logic     load_x;
        logic     prod_en;
        t_mul_sel mul_sel;
        logic     clip_en;
        logic     acc_en;
        logic     mem_en;
        logic     out_en;
    } t_dp_cmd;

endpackage

`default_nettype wire

### rtl/hctf_cfg.sv
// configuration register file
`default_nettype none

module hctf_cfg #(
    parameter int COEFF_BITS = hctf_pkg::COEFF_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [hctf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [hctf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic [hctf_pkg::GAIN_W-1:0]          o_pre_gain,
    output logic [hctf_pkg::CLIP_LVL_W-1:0]      o_clip_level,
    output logic [COEFF_BITS-1:0]                o_filter_coeff,
    output logic [hctf_pkg::TRIM_W-1:0]          o_post_scale,
    output logic [hctf_pkg::LIMIT_W-1:0]         o_peak_limit
);
    import hctf_pkg::*;

    // reset coefficient keeps its fractional value at any coefficient width
    localparam logic [63:0] COEFF_RST64 = (COEFF_BITS >= 16) ?
        (64'(FILTER_COEFF_R16) << (COEFF_BITS - 16)) :
        (64'(FILTER_COEFF_R16) >> (16 - COEFF_BITS));
    localparam logic [COEFF_BITS-1:0] COEFF_RST = COEFF_RST64[COEFF_BITS-1:0];

    logic [GAIN_W-1:0]     r_pre_gain;
    logic [CLIP_LVL_W-1:0] r_clip_level;
    logic [COEFF_BITS-1:0] r_filter_coeff;
    logic [TRIM_W-1:0]     r_post_scale;
    logic [LIMIT_W-1:0]    r_peak_limit;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre_gain     <= PRE_GAIN_RST;
            r_clip_level   <= CLIP_LEVEL_RST;
            r_filter_coeff <= COEFF_RST;
            r_post_scale   <= POST_SCALE_RST;
            r_peak_limit   <= PEAK_LIMIT_RST;
        end else if (i_cfg_valid) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_PRE_GAIN:     r_pre_gain     <= i_cfg_data[GAIN_W-1:0];
                REG_CLIP_LEVEL:   r_clip_level   <= i_cfg_data[CLIP_LVL_W-1:0];
                REG_FILTER_COEFF: r_filter_coeff <= i_cfg_data[COEFF_BITS-1:0];
                REG_POST_SCALE:   r_post_scale   <= i_cfg_data[TRIM_W-1:0];
                REG_PEAK_LIMIT:   r_peak_limit   <= i_cfg_data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_pre_gain     = r_pre_gain;
    assign o_clip_level   = r_clip_level;
    assign o_filter_coeff = r_filter_coeff;
    assign o_post_scale   = r_post_scale;
    assign o_peak_limit   = r_peak_limit;

endmodule

`default_nettype wire

### rtl/hctf_ctrl.sv
// sequencer for the shared multiplier datapath and output handshake
`default_nettype none

module hctf_ctrl (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output hctf_pkg::t_dp_cmd o_cmd
);
    import hctf_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_GAIN,
        S_CLIP,
        S_FF,
        S_SUM,
        S_TRIM,
        S_OUT
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    // output register can take a result this cycle
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        o_cmd         = '0;
        o_cmd.mul_sel = MUL_GAIN;
        n_state       = r_state;
        n_out_valid   = r_out_valid && i_out_stall;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_x = 1'b1;
                    n_state      = S_GAIN;
                end
            end
            S_GAIN: begin
                o_cmd.prod_en = 1'b1;
                o_cmd.mul_sel = MUL_GAIN;
                n_state       = S_CLIP;
            end
            S_CLIP: begin
                // clip the gain product while the feedback term is formed
                o_cmd.clip_en = 1'b1;
                o_cmd.prod_en = 1'b1;
                o_cmd.mul_sel = MUL_FB;
                n_state       = S_FF;
            end
            S_FF: begin
                o_cmd.acc_en  = 1'b1;
                o_cmd.prod_en = 1'b1;
                o_cmd.mul_sel = MUL_FF;
                n_state       = S_SUM;
            end
            S_SUM: begin
                o_cmd.mem_en = 1'b1;
                n_state      = S_TRIM;
            end
            S_TRIM: begin
                o_cmd.prod_en = 1'b1;
                o_cmd.mul_sel = MUL_TRIM;
                n_state       = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    o_cmd.out_en = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

### rtl/hctf_dp.sv
// datapath: shared multiplier, clipper, one-pole filter, trim and limiter
`default_nettype none

module hctf_dp #(
    parameter int SAMPLE_BITS = hctf_pkg::SAMPLE_BITS_DEF,
    parameter int COEFF_BITS  = hctf_pkg::COEFF_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire hctf_pkg::t_dp_cmd                 i_cmd,
    input  wire logic signed [SAMPLE_BITS-1:0]     i_sample_in,
    input  wire logic [hctf_pkg::GAIN_W-1:0]       i_pre_gain,
    input  wire logic [hctf_pkg::CLIP_LVL_W-1:0]   i_clip_level,
    input  wire logic [COEFF_BITS-1:0]             i_filter_coeff,
    input  wire logic [hctf_pkg::TRIM_W-1:0]       i_post_scale,
    input  wire logic [hctf_pkg::LIMIT_W-1:0]      i_peak_limit,
    input  wire logic                              i_rst_n,
    output logic signed [SAMPLE_BITS-1:0]          o_sample_out
);
    import hctf_pkg::*;

    // multiplier operand widths: signed data side, unsigned coefficient side
    localparam int MA = (SAMPLE_BITS > CLIP_W) ? SAMPLE_BITS : CLIP_W;
    localparam int MB = (COEFF_BITS + 2 > GAIN_W + 1) ? COEFF_BITS + 2 : GAIN_W + 1;
    localparam int PW = MA + MB;

    localparam logic [COEFF_BITS:0] ONE_C = {1'b1, {COEFF_BITS{1'b0}}};
    localparam logic [63:0] SMAX64 = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;
    localparam logic signed [PW-1:0] SMAX = signed'(SMAX64[PW-1:0]);
    localparam logic signed [PW-1:0] SMIN = -SMAX - PW'(1);

    logic signed [SAMPLE_BITS-1:0] r_x;
    logic signed [PW-1:0]          r_prod;
    logic signed [PW-1:0]          r_acc;
    logic signed [CLIP_W-1:0]      r_clip;
    logic signed [CLIP_W-1:0]      r_mem;
    logic signed [SAMPLE_BITS-1:0] r_out;

    logic signed [MA-1:0] mul_a;
    logic signed [MB-1:0] mul_b;
    logic [COEFF_BITS:0]  coeff_b;
    logic signed [PW-1:0] driven, clip_lim, clip_v;
    logic signed [PW-1:0] sum, y;
    logic signed [PW-1:0] trimmed, out_lim, lim_v, sat_v;

    // input weight is one minus the feedback weight
    assign coeff_b = ONE_C - {1'b0, i_filter_coeff};

    always_comb begin
        unique case (i_cmd.mul_sel)
            MUL_GAIN: begin
                mul_a = MA'(r_x);
                mul_b = signed'(MB'(i_pre_gain));
            end
            MUL_FB: begin
                mul_a = MA'(r_mem);
                mul_b = signed'(MB'(i_filter_coeff));
            end
            MUL_FF: begin
                mul_a = MA'(r_clip);
                mul_b = signed'(MB'(coeff_b));
            end
            MUL_TRIM: begin
                mul_a = MA'(r_mem);
                mul_b = signed'(MB'(i_post_scale));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // hard clip of the driven sample
    always_comb begin
        driven   = r_prod >>> GAIN_FRAC;
        clip_lim = signed'(PW'(i_clip_level));
        if (driven > clip_lim) begin
            clip_v = clip_lim;
        end else if (driven < -clip_lim) begin
            clip_v = -clip_lim;
        end else begin
            clip_v = driven;
        end
    end

    assign sum = r_prod + r_acc;
    assign y   = sum >>> COEFF_BITS;

    // trim, symmetric limit, then saturate to the sample range
    always_comb begin
        trimmed = r_prod >>> TRIM_FRAC;
        out_lim = signed'(PW'(i_peak_limit));
        if (trimmed > out_lim) begin
            lim_v = out_lim;
        end else if (trimmed < -out_lim) begin
            lim_v = -out_lim;
        end else begin
            lim_v = trimmed;
        end
        if (lim_v > SMAX) begin
            sat_v = SMAX;
        end else if (lim_v < SMIN) begin
            sat_v = SMIN;
        end else begin
            sat_v = lim_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_x) begin
            r_x <= i_sample_in;
        end
        if (i_cmd.prod_en) begin
            r_prod <= PW'(mul_a * mul_b);
        end
        if (i_cmd.acc_en) begin
            r_acc <= r_prod;
        end
        if (i_cmd.clip_en) begin
            r_clip <= clip_v[CLIP_W-1:0];
        end
        if (i_cmd.out_en) begin
            r_out <= sat_v[SAMPLE_BITS-1:0];
        end
    end

    // filter state is cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem <= '0;
        end else if (i_cmd.mem_en) begin
            r_mem <= y[CLIP_W-1:0];
        end
    end

    assign o_sample_out = r_out;

endmodule

`default_nettype wire

### rtl/hard_clip_tone_filter_top.sv
// top level of the hard clip tone filter
// Usage: one signed sample enters on the input channel (i_in_valid,
// o_in_stall, i_sample_in) and one processed sample leaves on the output
// channel (o_out_valid, i_out_stall, o_sample_out). A transaction
// completes at a clock edge with valid high and stall low.
// The sample is multiplied by pre_gain (Q8.8), hard clipped to
// +/- clip_level, run through the one-pole low-pass with weight
// filter_coeff, scaled by post_scale (Q1.15) and clamped to
// +/- peak_limit and to the sample range.
// A sample passes the GAIN, CLIP, FF, SUM, TRIM and OUT steps to the output
// register, and a new one is taken only once the block is idle again; the
// single shared multiplier is used four times per sample. o_in_stall is high
// while a sample is being worked on. A finished result waits in the output
// register while the receiver stalls; the next sample is accepted meanwhile
// and holds in its last step until the register frees. Registers are to be
// written by the user over i_cfg_valid/o_cfg_ready (always ready) only while
// the block is idle; the block itself does not enforce it. Synchronous reset
// loads register defaults, clears filter memory and empties output register.
`default_nettype none

module hard_clip_tone_filter_top #(
    parameter int SAMPLE_BITS = hctf_pkg::SAMPLE_BITS_DEF,
    parameter int COEFF_BITS  = hctf_pkg::COEFF_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic signed [SAMPLE_BITS-1:0]   i_sample_in,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic signed [SAMPLE_BITS-1:0]        o_sample_out,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [hctf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [hctf_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import hctf_pkg::*;

    logic [GAIN_W-1:0]     pre_gain;
    logic [CLIP_LVL_W-1:0] clip_level;
    logic [COEFF_BITS-1:0] filter_coeff;
    logic [TRIM_W-1:0]     post_scale;
    logic [LIMIT_W-1:0]    peak_limit;
    t_dp_cmd               dp_cmd;

    hctf_cfg #(
        .COEFF_BITS (COEFF_BITS)
    ) u_cfg (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_pre_gain     (pre_gain),
        .o_clip_level   (clip_level),
        .o_filter_coeff (filter_coeff),
        .o_post_scale   (post_scale),
        .o_peak_limit   (peak_limit)
    );

    hctf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (dp_cmd)
    );

    hctf_dp #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COEFF_BITS  (COEFF_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_cmd          (dp_cmd),
        .i_sample_in    (i_sample_in),
        .i_pre_gain     (pre_gain),
        .i_clip_level   (clip_level),
        .i_filter_coeff (filter_coeff),
        .i_post_scale   (post_scale),
        .i_peak_limit   (peak_limit),
        .i_rst_n        (i_rst_n),
        .o_sample_out   (o_sample_out)
    );

    // an accepted sample blocks the input until its result is produced
    a_busy_after_accept: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall
    ) else $error("input not stalled after accepting a sample");

    // a new result appears only from the final processing step
    a_result_from_busy: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall)
    ) else $error("result valid without a sample in flight");

    // reset leaves the block idle and empty
    a_reset_idle: assert property (
        @(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !o_in_stall)
    ) else $error("block not idle after reset");

endmodule

`default_nettype wire

### test/hard_clip_tone_filter_top_test.sv
// testbench for the hard clip tone filter: directed and random samples checked against a predictor
`timescale 1ns / 1ps

module hard_clip_tone_filter_top_test;
    import hctf_pkg::*;

    localparam int SW = SAMPLE_BITS_DEF;
    localparam int NUM_REGS = REG_PEAK_LIMIT + 1;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int DRAIN_CYCLES = 12;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_ITEMS = 160;
    localparam longint ONE_Q16 = longint'(1) << COEFF_BITS_DEF;
    localparam longint SMAX_L = (longint'(1) << (SW - 1)) - 1;
    localparam longint SMIN_L = -(longint'(1) << (SW - 1));
    localparam logic signed [SW-1:0] SMAX = SW'(SMAX_L);
    localparam logic signed [SW-1:0] SMIN = SW'(SMIN_L);

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_in_valid;
    logic                   o_in_stall;
    logic signed [SW-1:0]   i_sample_in;
    logic                   o_out_valid;
    logic                   i_out_stall;
    logic signed [SW-1:0]   o_sample_out;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    // register mirror and filter state of the predictor
    longint gain_q8   = longint'(PRE_GAIN_RST);
    longint clip_mag  = longint'(CLIP_LEVEL_RST);
    longint coeff_a   = longint'(FILTER_COEFF_R16);
    longint trim_q15  = longint'(POST_SCALE_RST);
    longint limit_mag = longint'(PEAK_LIMIT_RST);
    longint filt_mem  = 0;

    logic signed [SW-1:0] expected_samples[$];
    int mismatch_count = 0;
    int cycle_count = 0;
    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;
    int hold_request = 0;

    hard_clip_tone_filter_top u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_sample_in  (i_sample_in),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_sample_out (o_sample_out),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic longint clamp_mag(input longint v, input longint m);
        if (v > m)
            return m;
        if (v < -m)
            return -m;
        return v;
    endfunction

    // gain, clip, one-pole low-pass, trim and limit; advances the filter state
    function automatic logic signed [SW-1:0] clip_filter_trim(input logic signed [SW-1:0] s);
        longint x, clipped, y, t;
        x = longint'(s);
        clipped = clamp_mag((x * gain_q8) >>> GAIN_FRAC, clip_mag);
        y = ((ONE_Q16 - coeff_a) * clipped + coeff_a * filt_mem) >>> COEFF_BITS_DEF;
        filt_mem = y;
        t = clamp_mag((y * trim_q15) >>> TRIM_FRAC, limit_mag);
        if (t > SMAX_L)
            t = SMAX_L;
        if (t < SMIN_L)
            t = SMIN_L;
        return SW'(t);
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int unsigned p;
        p = $urandom_range(0, 99);
        if (p < 50)
            return 0;
        if (p < 85)
            return int'($urandom_range(1, 3));
        if (p < 97)
            return int'($urandom_range(4, 12));
        return int'($urandom_range(20, 60));
    endfunction

    function automatic logic signed [SW-1:0] rand_sample();
        logic signed [SW-1:0] r;
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 4))
                    0: r = SMAX;
                    1: r = SMIN;
                    2: r = '0;
                    3: r = SW'(1);
                    default: r = -SW'(1);
                endcase
            end
            1, 2, 3: r = SW'($urandom_range(0, 8191)) - SW'(4096);
            default: r = SW'($urandom);
        endcase
        return r;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_reg_value(input t_reg_idx r);
        int unsigned p;
        logic [CFG_DATA_W-1:0] v, upper;
        p = $urandom_range(0, 7);
        upper = CFG_DATA_W'($urandom);
        v = '0;
        case (r)
            REG_PRE_GAIN: begin
                case (p)
                    0: v = '0;
                    1: v = 24'h00FFFF;
                    2, 3, 4: v = CFG_DATA_W'($urandom_range(0, 1024));
                    default: v = CFG_DATA_W'($urandom_range(0, 65535));
                endcase
            end
            REG_CLIP_LEVEL: begin
                case (p)
                    0: v = '0;
                    1: v = 24'd8388608;
                    2: v = 24'hFFFFFF;
                    3, 4, 5: v = CFG_DATA_W'($urandom_range(6710886, 8388608));
                    default: v = CFG_DATA_W'($urandom_range(0, 8388608));
                endcase
            end
            REG_FILTER_COEFF: begin
                case (p)
                    0: v = '0;
                    1: v = 24'h00FFFF;
                    default: v = CFG_DATA_W'($urandom_range(0, 65535));
                endcase
            end
            REG_POST_SCALE: begin
                case (p)
                    0: v = '0;
                    1: v = 24'h00FFFF;
                    2, 3: v = 24'd32768;
                    default: v = CFG_DATA_W'($urandom_range(0, 65535));
                endcase
            end
            default: begin
                case (p)
                    0: v = '0;
                    1: v = 24'h7FFFFF;
                    2, 3, 4: v = CFG_DATA_W'($urandom_range(6710886, 8388607));
                    default: v = CFG_DATA_W'($urandom_range(0, 8388607));
                endcase
            end
        endcase
        // bits above the register width are dropped by the block
        if (r != REG_CLIP_LEVEL && p[0]) begin
            if (r == REG_PEAK_LIMIT)
                v[CFG_DATA_W-1] = upper[0];
            else
                v[CFG_DATA_W-1:GAIN_W] = upper[CFG_DATA_W-1:GAIN_W];
        end
        return v;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        case (idx)
            REG_PRE_GAIN:     gain_q8 = longint'(data[GAIN_W-1:0]);
            REG_CLIP_LEVEL:   clip_mag = longint'(data[CLIP_LVL_W-1:0]);
            REG_FILTER_COEFF: coeff_a = longint'(data[COEFF_BITS_DEF-1:0]);
            REG_POST_SCALE:   trim_q15 = longint'(data[TRIM_W-1:0]);
            REG_PEAK_LIMIT:   limit_mag = longint'(data[LIMIT_W-1:0]);
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_registers(input logic [CFG_DATA_W-1:0] gain,
                                 input logic [CFG_DATA_W-1:0] clip,
                                 input logic [CFG_DATA_W-1:0] coeff,
                                 input logic [CFG_DATA_W-1:0] trim,
                                 input logic [CFG_DATA_W-1:0] limit);
        write_reg(REG_PRE_GAIN, gain);
        write_reg(REG_CLIP_LEVEL, clip);
        write_reg(REG_FILTER_COEFF, coeff);
        write_reg(REG_POST_SCALE, trim);
        write_reg(REG_PEAK_LIMIT, limit);
    endtask

    // valid stays high after a transaction; the next call lowers it or drives new data
    task automatic send_sample(input logic signed [SW-1:0] s);
        int gap;
        gap = tx_idle_on ? pick_gap() : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_sample_in <= s;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        expected_samples.push_back(clip_filter_trim(s));
    endtask

    task automatic wait_for_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_samples.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic test_default_settings();
        send_sample('0);
        send_sample(SMAX);
        send_sample(SMIN);
        send_sample(SW'(1));
        send_sample(-SW'(1));
        send_sample(SW'(100000));
        wait_for_results();
    endtask

    task automatic test_register_extremes();
        // clip above full scale, coefficient zero, trim beyond unity
        set_registers(24'h00FFFF, 24'hFFFFFF, '0, 24'h00FFFF, 24'h7FFFFF);
        send_sample(SMAX);
        send_sample(SMIN);
        send_sample(SW'(1));
        send_sample(-SW'(1));
        wait_for_results();
        // zero clip level
        write_reg(REG_CLIP_LEVEL, '0);
        send_sample(SMAX);
        send_sample(SMIN);
        send_sample(SW'(12345));
        wait_for_results();
        // zero gain, full feedback, zero trim and limit
        set_registers('0, 24'd8388608, 24'h00FFFF, '0, '0);
        send_sample(SMAX);
        send_sample(SMIN);
        wait_for_results();
        // unity gain pass-through
        set_registers(24'd256, 24'd8388608, '0, 24'd32768, 24'h7FFFFF);
        send_sample(SMIN);
        send_sample(SMAX);
        send_sample(-SW'(1));
        wait_for_results();
        // indices past the register list change nothing
        for (int k = NUM_REGS; k < (1 << CFG_IDX_W); k++)
            write_reg(CFG_IDX_W'(k), CFG_DATA_W'($urandom));
        send_sample(SW'(4660));
        send_sample(-SW'(4660));
        wait_for_results();
    endtask

    task automatic test_backpressure();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        hold_request = 300;
        for (int n = 0; n < 40; n++)
            send_sample(rand_sample());
        wait_for_results();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        for (int n = 0; n < 20; n++)
            send_sample(rand_sample());
        wait_for_results();
    endtask

    task automatic test_random_settings();
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            set_registers(pick_reg_value(REG_PRE_GAIN), pick_reg_value(REG_CLIP_LEVEL),
                          pick_reg_value(REG_FILTER_COEFF), pick_reg_value(REG_POST_SCALE),
                          pick_reg_value(REG_PEAK_LIMIT));
            // every fourth phase runs with no idling on either side
            tx_idle_on = (ph % 4 != 3);
            rx_idle_on = (ph % 4 != 3);
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_sample(rand_sample());
            wait_for_results();
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    initial begin : out_stall_drive
        int left;
        logic level;
        left = 0;
        level = 1'b0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request > 0) begin
                left = hold_request;
                hold_request = 0;
                level = 1'b1;
            end else if (left == 0) begin
                level = rx_idle_on && ($urandom_range(0, 2) == 0);
                left = pick_gap() + 1;
            end
            i_out_stall <= level;
            left--;
        end
    end

    always @(posedge i_clk) begin : check_output
        logic signed [SW-1:0] want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_samples.size() == 0) begin
                $error("sample_out: no transaction expected, actual %0d", o_sample_out);
                mismatch_count++;
            end else begin
                want = expected_samples.pop_front();
                if (o_sample_out !== want) begin
                    $error("sample_out: expected %0d, actual %0d", want, o_sample_out);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_sample_in = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_default_settings();
        test_register_extremes();
        test_backpressure();
        test_random_settings();
        wait_for_results();
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

### files.f
rtl/hctf_pkg.sv
rtl/hctf_cfg.sv
rtl/hctf_ctrl.sv
rtl/hctf_dp.sv
rtl/hard_clip_tone_filter_top.sv
test/hard_clip_tone_filter_top_test.sv
